>>> rtl/tssc_pkg.sv
// Package for the target-sum subset counter.
// Holds sizes, the controller/datapath command and status structs, and the
// saturating add. No dependencies.
package tssc_pkg;

  localparam int MAX_SUM     = 1024;
  localparam int COUNT_BITS  = 32;
  localparam int ELEM_W      = 11;
  localparam int TARGET_W    = 12;
  localparam int IN_TDATA_W  = ((ELEM_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((COUNT_BITS + 7) / 8) * 8;
  localparam int TABLE_DEPTH = MAX_SUM + 1;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CMP_W       = ((ELEM_W > ADDR_W) ? ELEM_W : ADDR_W) + 1;
  localparam int SW          = ((TARGET_W > ADDR_W + 1) ? TARGET_W : ADDR_W + 1) + 1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  typedef struct packed {
    logic load_item;
    logic clear_wr;
    logic upd_rd;
    logic look_rd;
    logic load_result;
  } ctl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic at_elem;
    logic in_skip;
    logic last;
    logic wr_pending;
  } dp_stat_t;

  function automatic count_t sat_add(input count_t a, input count_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

endpackage

>>> rtl/tssc_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// No dependencies.
module tssc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

>>> rtl/tssc_datapath.sv
// Datapath: count table, read-add-write pipeline, running total, target
// register and result register. Depends on tssc_pkg and tssc_ram.
module tssc_datapath import tssc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ctl_cmd_t            cmd,
  output dp_stat_t            stat,
  input  logic [ELEM_W-1:0]   in_elem,
  input  logic                in_last,
  input  logic                cfg_wr_en,
  input  logic [TARGET_W-1:0] cfg_wr_data,
  output count_t              res_count,
  output logic                res_ovf
);

  logic [TARGET_W-1:0] target;
  logic [ELEM_W-1:0]   elem;
  logic                last;
  addr_t               cnt;
  addr_t               total;
  logic                ovf_seen;
  logic                wr_pending;
  addr_t               wr_addr;
  logic                hit_q;

  logic [CMP_W-1:0]    total_sum;
  logic [SW-1:0]       t_ext;
  logic [SW-1:0]       tot_ext;
  logic [SW-1:0]       s_plus;
  logic [SW-1:0]       s_minus;
  logic                hit;
  addr_t               idx;
  addr_t               elem_a;

  logic                ram_we;
  addr_t               ram_wa;
  count_t              ram_wd;
  logic                ram_re;
  addr_t               ram_ra;
  addr_t               ram_rb;
  count_t              rd_a;
  count_t              rd_b;

  assign elem_a    = addr_t'(elem);
  assign total_sum = CMP_W'(total) + CMP_W'(in_elem);

  // target window and parity check
  assign t_ext   = {{(SW-TARGET_W){target[TARGET_W-1]}}, target};
  assign tot_ext = {{(SW-ADDR_W){1'b0}}, total};
  assign s_plus  = tot_ext + t_ext;
  assign s_minus = tot_ext - t_ext;
  assign hit     = !ovf_seen && !s_plus[SW-1] && !s_minus[SW-1] && !s_plus[0];
  assign idx     = s_plus[ADDR_W:1];

  always_comb begin
    ram_we = cmd.clear_wr || wr_pending;
    ram_wa = cmd.clear_wr ? cnt : wr_addr;
    if (cmd.clear_wr) begin
      ram_wd = (cnt == '0) ? count_t'(1) : '0;
    end else begin
      ram_wd = sat_add(rd_a, rd_b);
    end
    ram_re = cmd.upd_rd || cmd.look_rd;
    ram_ra = cmd.look_rd ? idx : cnt;
    ram_rb = cnt - elem_a;
  end

  tssc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (ram_wa),
    .wr_data   (ram_wd),
    .rd_en     (ram_re),
    .rd_addr_a (ram_ra),
    .rd_addr_b (ram_rb),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      target     <= '0;
      cnt        <= addr_t'(MAX_SUM);
      total      <= '0;
      ovf_seen   <= 1'b0;
      wr_pending <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        target <= cfg_wr_data;
      end
      if (cmd.load_item || cmd.load_result) begin
        cnt <= addr_t'(MAX_SUM);
      end else if (cmd.clear_wr || cmd.upd_rd) begin
        cnt <= cnt - addr_t'(1);
      end
      if (cmd.load_result) begin
        total    <= '0;
        ovf_seen <= 1'b0;
      end else if (cmd.load_item) begin
        if (total_sum > CMP_W'(MAX_SUM)) begin
          total    <= addr_t'(MAX_SUM);
          ovf_seen <= 1'b1;
        end else begin
          total <= total_sum[ADDR_W-1:0];
        end
      end
      wr_pending <= cmd.upd_rd;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= cnt;
    if (cmd.load_item) begin
      elem <= in_elem;
      last <= in_last;
    end
    if (cmd.look_rd) begin
      hit_q <= hit;
    end
    if (cmd.load_result) begin
      res_count <= hit_q ? rd_a : '0;
      res_ovf   <= ovf_seen;
    end
  end

  assign stat.cnt_zero   = (cnt == '0);
  assign stat.at_elem    = (cnt == elem_a);
  assign stat.in_skip    = CMP_W'(in_elem) > CMP_W'(MAX_SUM);
  assign stat.last       = last;
  assign stat.wr_pending = wr_pending;

endmodule

>>> rtl/tssc_ctrl.sv
// Controller: sequences table clear, per-element update sweep, lookup and
// result handoff. Depends on tssc_pkg.
module tssc_ctrl import tssc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE,
    S_DRAIN,
    S_LOOKUP,
    S_RESULT
  } state_t;

  state_t state;

  assign in_ready        = (state == S_IDLE);
  assign cmd.load_item   = in_ready && in_valid;
  assign cmd.clear_wr    = (state == S_CLEAR);
  assign cmd.upd_rd      = (state == S_UPDATE);
  assign cmd.look_rd     = (state == S_LOOKUP);
  assign cmd.load_result = (state == S_RESULT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (stat.cnt_zero) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= stat.in_skip ? S_DRAIN : S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (stat.at_elem) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= stat.last ? S_LOOKUP : S_IDLE;
        end
        S_LOOKUP: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (cmd.load_result) begin
            state <= S_CLEAR;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

>>> rtl/target_sum_subset_count.sv
// Top level of the target-sum subset counter: stream ports, config port,
// controller and datapath. Depends on tssc_pkg, tssc_ctrl, tssc_datapath.
//
// Usage:
//   Elements enter on the s_axis channel, one per transfer; tlast marks the
//   final element of a sequence. Each element e <= MAX_SUM sweeps the count
//   table from MAX_SUM down to e, one entry per cycle through the table
//   RAM's read-add-write pipeline. The input is held off for the sweep and a
//   drain step (the drain alone above MAX_SUM). After the last element, one
//   result transfer leaves on m_axis: tdata is the number of sign
//   assignments reaching cfg target, tuser the overflow flag. The table is
//   then cleared, all MAX_SUM + 1 entries, and no element is taken
//   meanwhile. After reset the same clearing pass runs before the first
//   transfer. The target register resets to zero and is written through
//   cfg_wr_en / cfg_wr_data; the user must do so only while the block is
//   idle, which the block does not enforce. The result waits in an output
//   register while m_axis_tready is low; a following sequence's elements
//   are still processed, and only its own result waits for it.
module target_sum_subset_count import tssc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [10:0] element_value
  input  logic                   s_axis_tlast,   // last_element
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] way_count
  output logic                   m_axis_tuser,   // [0] sum_overflow
  input  logic                   cfg_wr_en,
  input  logic [TARGET_W-1:0]    cfg_wr_data     // target_value, signed
);

  ctl_cmd_t cmd;
  dp_stat_t stat;
  count_t   res_count;

  tssc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tssc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_elem     (s_axis_tdata[ELEM_W-1:0]),
    .in_last     (s_axis_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_count   (res_count),
    .res_ovf     (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_TDATA_W'(res_count);

  a_no_clear_during_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clear_wr && stat.wr_pending))
    else $error("table clear collides with pending update write");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !stat.wr_pending)
    else $error("element accepted while update write in flight");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrites an untaken result");

  a_sweep_follows_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && !cmd.load_result))
    else $error("accepted element did not start processing");

endmodule
